@@ rtl/string_to_unsigned_parser_assert.svh @@
// Assertion macros for the string to unsigned parser.
`ifndef STRING_TO_UNSIGNED_PARSER_ASSERT_SVH
`define STRING_TO_UNSIGNED_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define STP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/stp_pkg.sv @@
// Shared types and constants of the string to unsigned parser.
`timescale 1ns / 1ps

package stp_pkg;

	localparam int ACC_BITS  = 32;
	localparam int POS_BITS  = 12;
	localparam int BASE_BITS = 6;
	localparam int CH_BITS   = 8;

	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	typedef enum logic [2:0] {
		PH_WS     = 3'd0,
		PH_SIGN   = 3'd1,
		PH_ZERO   = 3'd2,
		PH_HEX    = 3'd3,
		PH_DIGITS = 3'd4,
		PH_DONE   = 3'd5
	} stp_phase_t;

	typedef struct packed {
		stp_phase_t           phase;
		logic [ACC_BITS-1:0]  acc;
		logic                 neg;
		logic                 ovf;
		logic                 seen;
		logic [BASE_BITS-1:0] base;
		logic [POS_BITS-1:0]  pos;
		logic [POS_BITS-1:0]  stop;
	} stp_state_t;

	localparam stp_state_t STATE_RESET = '{
		phase: PH_WS,
		acc:   '0,
		neg:   1'b0,
		ovf:   1'b0,
		seen:  1'b0,
		base:  '0,
		pos:   '0,
		stop:  '0
	};

	typedef struct packed {
		logic [CH_BITS-1:0] ch;
		logic               last;
	} stp_char_t;

	typedef struct packed {
		logic [ACC_BITS-1:0] value;
		logic                overflow;
		logic                any_digits;
		logic [POS_BITS-1:0] end_offset;
	} stp_result_t;

endpackage

@@ rtl/stp_step.sv @@
// Next parse state for one character: phase logic and digit multiply-add.
`timescale 1ns / 1ps

module stp_step (
	input  stp_pkg::stp_state_t               cur,
	input  logic [stp_pkg::CH_BITS-1:0]       ch,
	input  logic [stp_pkg::BASE_BITS-1:0]     number_base,
	output stp_pkg::stp_state_t               nxt
);

	localparam int MAC_BITS = stp_pkg::ACC_BITS + stp_pkg::BASE_BITS;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [6:0] DIGIT_NONE = 7'd99;

	localparam logic [stp_pkg::BASE_BITS-1:0] BASE_OCT = 6'd8;
	localparam logic [stp_pkg::BASE_BITS-1:0] BASE_DEC = 6'd10;
	localparam logic [stp_pkg::BASE_BITS-1:0] BASE_HEX = 6'd16;
	localparam logic [stp_pkg::BASE_BITS-1:0] BASE_AUTO = 6'd0;

	logic [6:0]                      dval;
	logic                            is_space;
	logic                            first;
	logic                            zero_prefix;
	logic [stp_pkg::BASE_BITS-1:0]   first_base;
	logic [stp_pkg::BASE_BITS-1:0]   tb;
	logic                            dig_ok;
	logic [MAC_BITS-1:0]             mac;
	logic                            ovf_now;
	logic [stp_pkg::POS_BITS-1:0]    pos_next;
	stp_pkg::stp_state_t             took;
	stp_pkg::stp_state_t             first_st;

	// digit symbol value, 0..35
	always_comb begin
		if (ch >= CH_0 && ch <= CH_9) begin
			dval = 7'(ch - CH_0);
		end else if (ch >= CH_UA && ch <= CH_UZ) begin
			dval = 7'(ch - CH_UA + 8'd10);
		end else if (ch >= CH_LA && ch <= CH_LZ) begin
			dval = 7'(ch - CH_LA + 8'd10);
		end else begin
			dval = DIGIT_NONE;
		end
	end

	assign is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
	assign pos_next = (cur.pos == stp_pkg::POS_MAX) ? cur.pos
		: cur.pos + stp_pkg::POS_BITS'(1);

	// base fixes at the first character past whitespace and sign
	assign first = (cur.phase == stp_pkg::PH_SIGN) ||
		((cur.phase == stp_pkg::PH_WS) && !is_space && ch != CH_MINUS && ch != CH_PLUS);
	assign first_base = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
	assign tb = first ? first_base : cur.base;
	assign zero_prefix = (ch == CH_0) &&
		(number_base == BASE_AUTO || number_base == BASE_HEX);

	// acc*base + d overflows exactly when the bits above ACC_BITS are set
	assign dig_ok  = (tb != '0) && ({1'b0, tb} > dval);
	assign mac     = ({{stp_pkg::BASE_BITS{1'b0}}, cur.acc} * {{stp_pkg::ACC_BITS{1'b0}}, tb})
		+ MAC_BITS'(dval);
	assign ovf_now = cur.ovf || (|mac[MAC_BITS-1:stp_pkg::ACC_BITS]);

	always_comb begin
		took = cur;
		took.base = tb;
		if (!dig_ok) begin
			took.phase = stp_pkg::PH_DONE;
		end else begin
			if (ovf_now) begin
				took.ovf = 1'b1;
			end else begin
				took.acc = mac[stp_pkg::ACC_BITS-1:0];
			end
			took.seen  = 1'b1;
			took.stop  = pos_next;
			took.phase = stp_pkg::PH_DIGITS;
		end
	end

	always_comb begin
		first_st = took;
		if (zero_prefix) begin
			first_st = cur;
			first_st.base  = (number_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
			first_st.acc   = '0;
			first_st.seen  = 1'b1;
			first_st.stop  = pos_next;
			first_st.phase = stp_pkg::PH_ZERO;
		end
	end

	always_comb begin
		nxt = cur;
		unique case (cur.phase)
			stp_pkg::PH_WS: begin
				priority if (is_space) begin
					nxt = cur;
				end else if (ch == CH_MINUS) begin
					nxt.neg   = 1'b1;
					nxt.phase = stp_pkg::PH_SIGN;
				end else if (ch == CH_PLUS) begin
					nxt.phase = stp_pkg::PH_SIGN;
				end else begin
					nxt = first_st;
				end
			end
			stp_pkg::PH_SIGN: begin
				nxt = first_st;
			end
			stp_pkg::PH_ZERO: begin
				if (ch == CH_LX || ch == CH_UX) begin
					nxt.base  = BASE_HEX;
					nxt.phase = stp_pkg::PH_HEX;
				end else begin
					nxt = took;
				end
			end
			stp_pkg::PH_HEX, stp_pkg::PH_DIGITS: begin
				nxt = took;
			end
			stp_pkg::PH_DONE: begin
				nxt = cur;
			end
			default: begin
				nxt = cur;
			end
		endcase
		nxt.pos = pos_next;
	end

endmodule

@@ rtl/string_to_unsigned_parser.sv @@
// Top level of the streaming strtoul-style unsigned integer parser.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------
//  cfg     | in  | cfg_valid / cfg_ready  | cfg_data: number_base, 6 bits
//  char    | in  | char_valid / char_ready| char_data: ch, last
//  res     | out | res_valid / res_ready  | res_data: value, overflow,
//          |     |                        |   any_digits, end_offset
//
// One character per cycle sustained while no last char waits for the result slot.
// A char transfer lands in the input register, from which the parse state is stepped
// (phase logic plus a 32x6 multiply-add whose upper bits flag overflow); that single
// step sets the rate. A last char passes the input register, then sets res_valid.
// One result slot: other chars keep flowing while it waits, a last char holds
// in the input register until it frees. arst_n clears state, base, valids.
`timescale 1ns / 1ps

module string_to_unsigned_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [stp_pkg::BASE_BITS-1:0]    cfg_data,
	input  logic                             char_valid,
	output logic                             char_ready,
	input  stp_pkg::stp_char_t               char_data,
	output logic                             res_valid,
	input  logic                             res_ready,
	output stp_pkg::stp_result_t             res_data
);

	logic [stp_pkg::BASE_BITS-1:0] base_q;

	// input register
	logic                 valid_s1;
	stp_pkg::stp_char_t   char_s1;

	// parse state and its next value
	stp_pkg::stp_state_t  state_q;
	stp_pkg::stp_state_t  state_nxt;

	// result register
	logic                 res_valid_q;
	stp_pkg::stp_result_t res_q;

	logic adv_s1;
	logic emit_s1;

	// config writes must arrive only while idle (the user's duty, not enforced); always take them
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	// a last character needs the result slot; others step freely
	assign adv_s1     = valid_s1 && (!char_s1.last || !res_valid_q || res_ready);
	assign emit_s1    = adv_s1 && char_s1.last;
	assign char_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && char_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			char_s1 <= char_data;
		end
	end

	stp_step u_step (
		.cur         (state_q),
		.ch          (char_s1.ch),
		.number_base (base_q),
		.nxt         (state_nxt)
	);

	// parse state returns to reset after the string's last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stp_pkg::STATE_RESET;
		end else if (adv_s1) begin
			state_q <= char_s1.last ? stp_pkg::STATE_RESET : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_s1) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// value saturates on overflow, else two's complement after a minus
	always_ff @(posedge clk) begin
		if (emit_s1) begin
			if (state_nxt.ovf) begin
				res_q.value <= '1;
			end else if (state_nxt.neg) begin
				res_q.value <= '0 - state_nxt.acc;
			end else begin
				res_q.value <= state_nxt.acc;
			end
			res_q.overflow   <= state_nxt.ovf;
			res_q.any_digits <= state_nxt.seen;
			res_q.end_offset <= state_nxt.seen ? state_nxt.stop : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

`include "string_to_unsigned_parser_assert.svh"

	`STP_ASSERT_NOW(a_ovf_saturates, res_valid && res_data.overflow, res_data.value == '1, "overflow result not all ones")
	`STP_ASSERT_NOW(a_no_digit_zero, res_valid && !res_data.any_digits, res_data.value == '0 && res_data.end_offset == '0, "digitless result not zero")
	`STP_ASSERT_NEXT(a_last_emits, emit_s1, res_valid, "last character gave no result")
	`STP_ASSERT_NEXT(a_last_clears, emit_s1, state_q.phase == stp_pkg::PH_WS && state_q.pos == '0, "parse state not cleared after result")

endmodule

@@ dv/parse_checker.sv @@
// Scoreboard for the string to unsigned parser: predicts each result and compares it.
`timescale 1ns / 1ps

module parse_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [stp_pkg::BASE_BITS-1:0] cfg_data,
	input  logic                          char_valid,
	input  logic                          char_ready,
	input  stp_pkg::stp_char_t            char_data,
	input  logic                          res_valid,
	input  logic                          res_ready,
	input  stp_pkg::stp_result_t          res_data,
	output int                            errors,
	output int                            pending
);
	import stp_pkg::*;

	// predicted parse state
	logic [BASE_BITS-1:0] number_base;
	stp_phase_t           phase;
	logic [ACC_BITS-1:0]  acc;
	logic                 neg;
	logic                 ovf;
	logic                 seen;
	logic [BASE_BITS-1:0] radix;
	logic [POS_BITS-1:0]  pos;
	logic [POS_BITS-1:0]  stop;
	stp_result_t          expected_results[$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("checker: %0t %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic clear_parse();
		phase = PH_WS;
		acc   = '0;
		neg   = 1'b0;
		ovf   = 1'b0;
		seen  = 1'b0;
		radix = '0;
		pos   = '0;
		stop  = '0;
	endtask

	// positions saturate
	function automatic logic [POS_BITS-1:0] pos_next();
		return (pos == POS_MAX) ? pos : pos + 1'b1;
	endfunction

	// 0..35, 99 for anything that is no digit symbol
	function automatic int unsigned digit_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 32'(c - "0");
		if (c >= "A" && c <= "Z") return c - "A" + 10;
		if (c >= "a" && c <= "z") return c - "a" + 10;
		return 99;
	endfunction

	task automatic take_digit(input logic [7:0] c);
		int unsigned         d;
		logic [ACC_BITS-1:0] cutoff;
		logic [ACC_BITS-1:0] cutlim;
		d = digit_of(c);
		if (radix == 0 || d >= radix) begin
			phase = PH_DONE;
		end else begin
			cutoff = {ACC_BITS{1'b1}} / radix;
			cutlim = {ACC_BITS{1'b1}} % radix;
			if (ovf || acc > cutoff || (acc == cutoff && d > cutlim)) begin
				ovf = 1'b1;
			end else begin
				acc = acc * radix + d;
			end
			seen  = 1'b1;
			stop  = pos_next();
			phase = PH_DIGITS;
		end
	endtask

	// first character after whitespace and sign fixes the radix
	task automatic first_char(input logic [7:0] c);
		if (c == "0" && (number_base == 0 || number_base == 16)) begin
			radix = (number_base == 0) ? 6'd8 : 6'd16;
			acc   = '0;
			seen  = 1'b1;
			stop  = pos_next();
			phase = PH_ZERO;
		end else begin
			radix = (number_base == 0) ? 6'd10 : number_base;
			take_digit(c);
		end
	endtask

	task automatic parse_char(input stp_char_t item);
		stp_result_t r;
		case (phase)
			PH_WS: begin
				if (item.ch == 8'd32 || (item.ch >= 8'd9 && item.ch <= 8'd13)) begin
				end else if (item.ch == "-") begin
					neg   = 1'b1;
					phase = PH_SIGN;
				end else if (item.ch == "+") begin
					phase = PH_SIGN;
				end else begin
					first_char(item.ch);
				end
			end
			PH_SIGN: first_char(item.ch);
			PH_ZERO: begin
				if (item.ch == "x" || item.ch == "X") begin
					radix = 6'd16;
					phase = PH_HEX;
				end else begin
					take_digit(item.ch);
				end
			end
			PH_HEX, PH_DIGITS: take_digit(item.ch);
			default: ;
		endcase
		pos = pos_next();
		if (item.last) begin
			r.value      = ovf ? {ACC_BITS{1'b1}} : (neg ? -acc : acc);
			r.overflow   = ovf;
			r.any_digits = seen;
			r.end_offset = seen ? stop : '0;
			expected_results.push_back(r);
			clear_parse();
		end
	endtask

	task automatic check_result(input stp_result_t got);
		stp_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result with none due, value", got.value, 0);
		end else begin
			want = expected_results.pop_front();
			if (got.value !== want.value)
				report_mismatch("value", got.value, want.value);
			if (got.overflow !== want.overflow)
				report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
			if (got.any_digits !== want.any_digits)
				report_mismatch("any_digits", 32'(got.any_digits), 32'(want.any_digits));
			if (got.end_offset !== want.end_offset)
				report_mismatch("end_offset", 32'(got.end_offset), 32'(want.end_offset));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base = '0;
			clear_parse();
			expected_results.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) number_base = cfg_data;
			if (char_valid && char_ready) parse_char(char_data);
			if (res_valid && res_ready) check_result(res_data);
			pending <= expected_results.size();
		end
	end

endmodule

@@ dv/testbench.sv @@
// Top of the parser testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module testbench;
	import stp_pkg::*;

	localparam int RESET_CYCLES  = 4;
	localparam int SETTLE_CYCLES = 4;     // margin after the last result is checked
	localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
	localparam int IDLE_PCT      = 24;
	localparam int RANDOM_CHARS  = 1300;
	localparam int PHASES        = 10;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [BASE_BITS-1:0] cfg_data   = '0;
	logic                 char_valid = 1'b0;
	logic                 char_ready;
	stp_char_t            char_data  = '0;
	logic                 res_valid;
	logic                 res_ready  = 1'b0;
	stp_result_t          res_data;

	int check_errors;
	int results_due;

	// shared between the sender and the receiver
	bit no_idle      = 1'b0;
	bit hold_request = 1'b0;

	logic [BASE_BITS-1:0] cur_base = '0;
	logic [7:0]           text_buf[$];
	int                   sent_chars = 0;
	// radix per random phase: auto, common ones, both extremes, base one, above 36
	int                   phase_bases[PHASES] = '{0, 10, 16, 2, 36, 63, 1, 8, 0, 0};

	string_to_unsigned_parser u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_data  (char_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data)
	);

	parse_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_data  (char_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data),
		.errors     (check_errors),
		.pending    (results_due)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard limit on the run; the slowest legal run is well under a tenth of this.
	initial begin
		#4_000_000;
		$display("testbench: errors");
		$finish;
	end

	// Result side. ready toggles at random, except in the no-idle stretch. When the
	// sender asks for a hold-off, ready is held low while HOLD_CYCLES are counted here.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				res_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// One char transfer. Idle cycles come first, each taken at the idle odds;
	// otherwise valid stays high from the previous transfer and only the
	// payload moves on.
	task automatic send_char(input logic [7:0] c, input logic fin);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_data  <= '{ch: c, last: fin};
		@(posedge clk);
		while (!char_ready) @(posedge clk);
	endtask

	// Send the buffered string; the final char carries last when asked.
	task automatic send_text(input bit mark_last);
		for (int i = 0; i < text_buf.size(); i++)
			send_char(text_buf[i], mark_last && (i == text_buf.size() - 1));
		sent_chars += text_buf.size();
	endtask

	task automatic load_text(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
	endtask

	// Stop offering chars and wait until every predicted result has been
	// checked. The extra cycles cover chars that make no result but may still
	// sit in the input register.
	task automatic drain();
		char_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// number_base is only written once chars and results drain; a string may be open
	task automatic write_base(input logic [BASE_BITS-1:0] b);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= b;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_base = b;
	endtask

	function automatic logic [7:0] glyph(input int unsigned d);
		if (d < 10) return 8'("0" + d);
		return 8'(($urandom_range(1) ? "a" : "A") + d - 10);
	endfunction

	// Mostly well-formed numbers: whitespace, a sign, maybe a prefix, digits of
	// the active radix (long runs overflow), then usually a terminator. The rest is raw
	// noise, doubled signs and stray chars among the digits.
	task automatic build_random_text();
		int unsigned radix;
		int unsigned count;
		int unsigned pick;
		text_buf.delete();
		if ($urandom_range(99) < 12) begin
			repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(3)) begin
				pick = $urandom_range(5);
				text_buf.push_back(pick == 5 ? 8'd32 : 8'(9 + pick));
			end
			pick = $urandom_range(99);
			if (pick < 5) begin
				text_buf.push_back("+");
				text_buf.push_back("-");
			end else if (pick < 30) begin
				text_buf.push_back("-");
			end else if (pick < 45) begin
				text_buf.push_back("+");
			end
			radix = (cur_base == 0) ? 10 : ((cur_base > 36) ? 36 : cur_base);
			if ((cur_base == 0 || cur_base == 16) && $urandom_range(2) == 0) begin
				text_buf.push_back("0");
				if ($urandom_range(2) != 0) begin
					text_buf.push_back($urandom_range(1) ? "x" : "X");
					radix = 16;
				end else if (cur_base == 0) begin
					radix = 8;
				end
			end
			count = ($urandom_range(99) < 85) ? $urandom_range(10) : $urandom_range(11, 40);
			repeat (count)
				text_buf.push_back(($urandom_range(99) < 4) ? 8'($urandom_range(255))
					: glyph($urandom_range(radix - 1)));
			pick = $urandom_range(99);
			if (pick < 60) begin
				text_buf.push_back(8'd0);
			end else if (pick < 80) begin
				text_buf.push_back(8'($urandom_range(255)));
				text_buf.push_back(8'd0);
			end
		end
		if (text_buf.size() == 0) text_buf.push_back(8'd0);
	endtask

	initial begin
		int phase_start;

		phase_bases[PHASES-1] = $urandom_range(63);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings, radix auto after reset: sign with hex prefix,
		// prefix without a hex digit, a high char with no digits, octal.
		load_text(" -0XfF");
		send_text(1);
		load_text("0xg");
		send_text(1);
		text_buf.delete();
		text_buf.push_back(8'h80);
		send_text(1);
		load_text("017");
		send_text(1);

		// radix written after whitespace and sign: the new one applies
		load_text(" -");
		send_text(0);
		write_base(16);
		load_text("ff");
		send_text(1);
		// radix written after the first digit: the old one stays
		load_text("1");
		send_text(0);
		write_base(2);
		load_text("9");
		send_text(1);

		write_base(36);
		load_text("zZ");
		send_text(1);
		write_base(63);
		load_text("Z");
		send_text(1);
		write_base(1);
		load_text("01");
		send_text(1);

		// Random phases, one radix each. Phase 2 runs without idles on either
		// side; phase 4 starts with a long receiver hold-off so the result
		// register fills and char_ready drops while chars keep coming.
		sent_chars = 0;
		for (int p = 0; p < PHASES; p++) begin
			write_base(BASE_BITS'(phase_bases[p]));
			no_idle = (p == 2);
			if (p == 4) hold_request = 1'b1;
			phase_start = sent_chars;
			while (sent_chars - phase_start < RANDOM_CHARS / PHASES) begin
				build_random_text();
				send_text(1);
			end
		end
		no_idle = 1'b0;

		drain();
		if (check_errors == 0 && results_due == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
